@@ hw/rtl/gpm_pkg.sv @@
// ----------------------------------------------------------------------------
// gpm_pkg
// Shared types, constants and helpers for the Gray-coded PAM mapper/demapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpm_pkg;

    localparam int MAX_BPS = 8;
    localparam int FRAC    = 8;
    localparam int VAL_W   = 20;
    localparam int PN_W    = 15;
    localparam int BPS_W   = 4;
    localparam int PS_W    = MAX_BPS + 2;
    localparam int PROD_W  = PS_W + PN_W + 1;
    localparam int SH      = 14 - FRAC;
    localparam int SHW     = MAX_BPS + FRAC;
    localparam int DW      = ((SHW > VAL_W) ? SHW : VAL_W) + 2;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_BPS  = 2'd1;
    localparam logic [1:0] REG_PN   = 2'd2;

    localparam logic MODE_MOD   = 1'b0;
    localparam logic MODE_DEMOD = 1'b1;

    localparam logic signed [31:0] VAL_MAX = 32'sd524287;
    localparam logic signed [31:0] VAL_MIN = -32'sd524288;

    typedef struct packed {
        logic             mode;
        logic [BPS_W-1:0] bps;
        logic [PN_W-1:0]  pn;
    } t_cfg;

    function automatic logic signed [VAL_W-1:0] sat20(input logic signed [31:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > VAL_MAX) begin
            r = VAL_MAX[VAL_W-1:0];
        end else if (v < VAL_MIN) begin
            r = VAL_MIN[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gpm_cfg.sv @@
// ----------------------------------------------------------------------------
// gpm_cfg
// APB register file holding mode, bits per symbol and power normalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpm_cfg
    import gpm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic             r_mode;
    logic [BPS_W-1:0] r_bps;
    logic [PN_W-1:0]  r_pn;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MOD;
            r_bps  <= BPS_W'(1);
            r_pn   <= PN_W'(16384);
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_MODE: r_mode <= pwdata[0];
                REG_BPS:  r_bps  <= pwdata[BPS_W-1:0];
                REG_PN:   r_pn   <= pwdata[PN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE: prdata = {31'd0, r_mode};
            REG_BPS:  prdata = {{(32-BPS_W){1'b0}}, r_bps};
            REG_PN:   prdata = {{(32-PN_W){1'b0}}, r_pn};
            default:  prdata = 32'd0;
        endcase
    end

    always_comb begin
        o_cfg.mode = r_mode;
        o_cfg.pn   = r_pn;
        if (r_bps == BPS_W'(0)) begin
            o_cfg.bps = BPS_W'(1);
        end else if (r_bps > BPS_W'(MAX_BPS)) begin
            o_cfg.bps = BPS_W'(MAX_BPS);
        end else begin
            o_cfg.bps = r_bps;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/gpm_mapper.sv @@
// ----------------------------------------------------------------------------
// gpm_mapper
// Gray-coded PAM symbol accumulator with normalizer scaling and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpm_mapper
    import gpm_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_update,
    input  wire logic                    i_bit,
    input  wire logic [BPS_W-1:0]        i_bps,
    input  wire logic [PN_W-1:0]         i_pn,
    output logic                         o_emit,
    output logic signed [VAL_W-1:0]      o_value
);

    logic [BPS_W-1:0]         r_count;
    logic signed [PS_W-1:0]   r_sym;
    logic                     r_sign;
    logic [BPS_W-1:0]         n_count;
    logic signed [PS_W-1:0]   n_sym;
    logic                     n_sign;
    logic [PS_W-1:0]          w_step;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_shr;

    assign n_sign  = i_bit ? ~r_sign : r_sign;
    assign w_step  = n_sign ? {{(PS_W-1){1'b0}}, 1'b1} : {PS_W{1'b1}};
    assign n_sym   = (r_sym <<< 1) + $signed(w_step);
    assign n_count = r_count + BPS_W'(1);
    assign o_emit  = n_count >= i_bps;

    assign w_prod  = $signed(PROD_W'(n_sym)) * $signed({{(PROD_W-PN_W){1'b0}}, i_pn});
    assign w_shr   = w_prod >>> SH;
    assign o_value = sat20(32'(w_shr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sym   <= '0;
            r_sign  <= 1'b1;
        end else if (i_update) begin
            if (o_emit) begin
                r_count <= '0;
                r_sym   <= '0;
                r_sign  <= 1'b1;
            end else begin
                r_count <= n_count;
                r_sym   <= n_sym;
                r_sign  <= n_sign;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/gpm_demapper.sv @@
// ----------------------------------------------------------------------------
// gpm_demapper
// Soft-value sequencer: one |a| minus halving-shift step per output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpm_demapper
    import gpm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic                     i_step,
    input  wire logic signed [VAL_W-1:0]  i_amplitude,
    input  wire logic [BPS_W-1:0]         i_bps,
    output logic                          o_busy,
    output logic                          o_last,
    output logic signed [VAL_W-1:0]       o_value
);

    localparam logic [SHW-1:0] BASE = SHW'(1) << FRAC;

    logic signed [VAL_W-1:0] r_a;
    logic [SHW-1:0]          r_shift;
    logic [BPS_W-1:0]        r_rem;
    logic signed [VAL_W-1:0] w_src;
    logic [SHW-1:0]          w_sh;
    logic [SHW-1:0]          w_init;
    logic signed [DW-1:0]    w_abs;
    logic signed [DW-1:0]    w_diff;

    assign w_init = BASE << (i_bps - BPS_W'(1));
    assign w_src  = i_start ? i_amplitude : r_a;
    assign w_sh   = i_start ? w_init : r_shift;
    assign w_abs  = w_src[VAL_W-1] ? -DW'(w_src) : DW'(w_src);
    assign w_diff = w_abs - $signed({{(DW-SHW){1'b0}}, w_sh});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_start) begin
            r_rem <= i_bps - BPS_W'(1);
        end else if (i_step) begin
            r_rem <= r_rem - BPS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start || i_step) begin
            r_a     <= sat20(32'(w_diff));
            r_shift <= w_sh >> 1;
        end
    end

    assign o_busy  = r_rem != BPS_W'(0);
    assign o_last  = r_rem == BPS_W'(1);
    assign o_value = r_a;

endmodule

`default_nettype wire

@@ hw/rtl/gray_pam_mapper_demapper.sv @@
// ----------------------------------------------------------------------------
// gray_pam_mapper_demapper
// Gray-coded PAM mapper and soft demapper selected by a mode register.
// ----------------------------------------------------------------------------
// An accepted beat is held in the input register until the mapper or demapper
// takes it; a new amplitude waits until all soft values of the last one are out.
// Modulate takes one bit per cycle unless a symbol waits on a stalled output; each
// amplitude gives bits_per_symbol soft values, one per cycle unless stalled.
// Synchronous reset restores the register defaults and clears the symbol state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gray_pam_mapper_demapper
    import gpm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_in_bit,
    input  wire logic signed [VAL_W-1:0]  i_in_amplitude,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [VAL_W-1:0]       o_out_value,
    output logic                          o_out_last,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [3:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready
);

    t_cfg                    w_cfg;
    logic                    r_iv;
    logic                    r_bit;
    logic signed [VAL_W-1:0] r_amp;
    logic                    r_ov;
    logic signed [VAL_W-1:0] r_val;
    logic                    r_last;
    logic                    w_out_free;
    logic                    w_proc;
    logic                    w_step;
    logic                    w_in_ready;
    logic                    w_emit;
    logic signed [VAL_W-1:0] w_mod_val;
    logic                    w_busy;
    logic                    w_dm_last;
    logic signed [VAL_W-1:0] w_dm_val;

    gpm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    gpm_mapper u_mapper (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_proc && (w_cfg.mode == MODE_MOD)),
        .i_bit    (r_bit),
        .i_bps    (w_cfg.bps),
        .i_pn     (w_cfg.pn),
        .o_emit   (w_emit),
        .o_value  (w_mod_val)
    );

    gpm_demapper u_demapper (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_proc && (w_cfg.mode == MODE_DEMOD)),
        .i_step      (w_step),
        .i_amplitude (r_amp),
        .i_bps       (w_cfg.bps),
        .o_busy      (w_busy),
        .o_last      (w_dm_last),
        .o_value     (w_dm_val)
    );

    assign w_out_free = !r_ov || !i_stall;
    assign w_step     = w_busy && w_out_free;
    assign w_proc     = r_iv && !w_busy &&
                        ((w_cfg.mode == MODE_MOD && !w_emit) || w_out_free);
    assign w_in_ready = !r_iv || w_proc;
    assign o_stall    = !w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_valid && w_in_ready) begin
            r_iv <= 1'b1;
        end else if (w_proc) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_in_ready) begin
            r_bit <= i_in_bit;
            r_amp <= i_in_amplitude;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_step) begin
            r_ov <= 1'b1;
        end else if (w_proc && (w_cfg.mode == MODE_DEMOD || w_emit)) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_val  <= w_dm_val;
            r_last <= w_dm_last;
        end else if (w_proc && w_cfg.mode == MODE_DEMOD) begin
            r_val  <= r_amp;
            r_last <= w_cfg.bps == BPS_W'(1);
        end else if (w_proc && w_emit) begin
            r_val  <= w_mod_val;
            r_last <= 1'b1;
        end
    end

    assign o_valid     = r_ov;
    assign o_out_value = r_val;
    assign o_out_last  = r_last;

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_proc)
        else $error("input beat consumed while soft values are pending");

    a_busy_holds_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> r_ov)
        else $error("soft sequence pending without a result held");

    a_not_last_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_last) |-> w_busy)
        else $error("non-final soft value without a following value");

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_cfg.mode == MODE_DEMOD && w_cfg.bps != BPS_W'(1)) |=> w_busy)
        else $error("multi-bit demodulation did not start a soft sequence");

endmodule

`default_nettype wire
